/* rtl/hkm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the heartbeat keepalive monitor.
// No dependencies; every other file of the block uses this package.
package hkm_pkg;

	// Event codes carried by each input item
	typedef enum logic [1:0] {
		OP_POLL  = 2'd0,
		OP_SENT  = 2'd1,
		OP_PONG  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_ENABLE   = 2'd0,
		REG_INTERVAL = 2'd1,
		REG_TIMEOUT  = 2'd2,
		REG_LIMIT    = 2'd3
	} reg_idx_t;

	localparam int unsigned TIME_W  = 64;  // microsecond timestamp
	localparam int unsigned MS_W    = 32;  // millisecond settings and wait
	localparam int unsigned US_W    = 42;  // a 32-bit ms value times 1000 fits here
	localparam int unsigned MISS_W  = 16;
	localparam int unsigned CDATA_W = 32;

	localparam logic [9:0] MS_TO_US = 10'd1000;

	// Reset values of the configuration registers
	localparam logic             RST_ENABLE   = 1'b1;
	localparam logic [MS_W-1:0]  RST_INTERVAL = 32'd10000;
	localparam logic [MS_W-1:0]  RST_TIMEOUT  = 32'd5000;
	localparam logic [MISS_W-1:0] RST_LIMIT   = 16'd3;

	// Divide by 1000 as (x >> 3) / 125, with x >> 3 split at bit SPLIT:
	// 2^21 = 16777 * 125 + 27, so x/125 = a*16777 + (a*27 + b)/125.
	// The small quotient uses a reciprocal of 2^31/125, exact below 2^24.
	localparam int unsigned REM_W    = US_W - 3;
	localparam int unsigned SPLIT    = 21;
	localparam int unsigned HI_W     = REM_W - SPLIT;
	localparam int unsigned Y_W      = 24;
	localparam int unsigned RCP_SH   = 31;
	localparam logic [14:0] DIV_HI   = 15'd16777;
	localparam logic [4:0]  DIV_MID  = 5'd27;
	localparam logic [24:0] DIV_RCP  = 25'd17179870;

	// Settings as seen by the datapath
	typedef struct packed {
		logic              enable;
		logic [MS_W-1:0]   ping_ms;
		logic [US_W-1:0]   ping_us;
		logic [US_W-1:0]   pong_us;
		logic [MISS_W-1:0] miss_limit;
		logic              clear;       // a register write clears tracking state
	} cfg_t;

	// Status after the state update, handed to the wait computation
	typedef struct packed {
		logic              fired;
		logic              dead;
		logic [MISS_W-1:0] misses;
		logic              pending;
		logic              active;      // enabled, alive and no pong pending
		logic [TIME_W-1:0] elapsed;     // time since the send stamp after the update
	} status_t;

endpackage

/* rtl/hkm_intf.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the heartbeat keepalive monitor:
// input items, result items and configuration writes. Uses hkm_pkg.
interface hkm_item_if;
	logic                      valid;
	logic                      ready;
	hkm_pkg::op_t              operation;
	logic [hkm_pkg::TIME_W-1:0] now_us;

	modport source (output valid, output operation, output now_us, input ready);
	modport sink   (input valid, input operation, input now_us, output ready);
endinterface

interface hkm_result_if;
	logic                       valid;
	logic                       ready;
	logic                       timeout_fired;
	logic                       send_due;
	logic [hkm_pkg::MS_W-1:0]   wait_ms;
	logic                       peer_dead;
	logic [hkm_pkg::MISS_W-1:0] misses;
	logic                       awaiting_pong;

	modport source (output valid, output timeout_fired, output send_due, output wait_ms,
		output peer_dead, output misses, output awaiting_pong, input ready);
	modport sink   (input valid, input timeout_fired, input send_due, input wait_ms,
		input peer_dead, input misses, input awaiting_pong, output ready);
endinterface

interface hkm_cfg_if;
	logic                        valid;
	logic                        ready;
	hkm_pkg::reg_idx_t           index;
	logic [hkm_pkg::CDATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/hkm_cfg_regs.sv */
`timescale 1ns / 1ps
// Configuration registers of the heartbeat keepalive monitor, with the
// millisecond settings also kept in microseconds. Uses hkm_pkg, hkm_intf.
module hkm_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	hkm_cfg_if.sink      cfg,
	output hkm_pkg::cfg_t cfg_o
);
	import hkm_pkg::*;

	logic              enable_q;
	logic [MS_W-1:0]   ping_ms_q;
	logic [US_W-1:0]   ping_us_q;
	logic [US_W-1:0]   pong_us_q;
	logic [MISS_W-1:0] limit_q;
	logic              wr;
	logic [US_W-1:0]   data_us;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;
	assign data_us   = US_W'({10'd0, cfg.data} * {32'd0, MS_TO_US});

	// Write one register per item; scale the ms settings once here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= RST_ENABLE;
			ping_ms_q <= RST_INTERVAL;
			ping_us_q <= US_W'(RST_INTERVAL) * US_W'(MS_TO_US);
			pong_us_q <= US_W'(RST_TIMEOUT) * US_W'(MS_TO_US);
			limit_q   <= RST_LIMIT;
		end else if (wr) begin
			unique case (cfg.index)
				REG_ENABLE: enable_q <= cfg.data[0];
				REG_INTERVAL: begin
					ping_ms_q <= cfg.data;
					ping_us_q <= data_us;
				end
				REG_TIMEOUT: pong_us_q <= data_us;
				REG_LIMIT: limit_q <= cfg.data[MISS_W-1:0];
				default: enable_q <= enable_q;
			endcase
		end
	end

	always_comb begin
		cfg_o.enable     = enable_q;
		cfg_o.ping_ms    = ping_ms_q;
		cfg_o.ping_us    = ping_us_q;
		cfg_o.pong_us    = pong_us_q;
		cfg_o.miss_limit = limit_q;
		cfg_o.clear      = wr;
	end

endmodule

/* rtl/hkm_state_core.sv */
`timescale 1ns / 1ps
// Input register and keepalive state update of the heartbeat keepalive
// monitor; hands a status record to the wait computation. Uses hkm_pkg, hkm_intf.
module hkm_state_core (
	input  logic            clk,
	input  logic            arst_n,
	input  hkm_pkg::cfg_t   cfg_i,
	hkm_item_if.sink        item,
	output logic            st_valid,
	input  logic            st_ready,
	output hkm_pkg::status_t st_o
);
	import hkm_pkg::*;

	// Input stage
	logic              valid_s1;
	op_t               op_s1;
	logic [TIME_W-1:0] now_s1;
	// Status stage
	logic              valid_s2;
	status_t           st_s2;
	// Keepalive state
	logic [TIME_W-1:0] stamp_q;
	logic              pending_q;
	logic              dead_q;
	logic [MISS_W-1:0] miss_q;

	logic              adv1;
	logic              adv2;
	logic              upd;
	logic [TIME_W-1:0] diff;
	logic              overdue;
	logic [MISS_W-1:0] miss_inc;
	logic [TIME_W-1:0] stamp_d;
	logic              pending_d;
	logic              dead_d;
	logic [MISS_W-1:0] miss_d;
	logic              fired_d;
	logic [TIME_W-1:0] elapsed_d;

	assign adv2       = !valid_s2 || st_ready;
	assign adv1       = !valid_s1 || adv2;
	assign item.ready = adv1;
	assign upd        = valid_s1 && adv2;

	// Capture the incoming item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && item.valid) begin
			op_s1  <= item.operation;
			now_s1 <= item.now_us;
		end
	end

	// Apply the event to the keepalive state
	assign diff     = now_s1 - stamp_q;
	assign overdue  = diff >= TIME_W'(cfg_i.pong_us);
	assign miss_inc = (miss_q == '1) ? miss_q : miss_q + 1'b1;

	always_comb begin
		stamp_d   = stamp_q;
		pending_d = pending_q;
		dead_d    = dead_q;
		miss_d    = miss_q;
		fired_d   = 1'b0;
		elapsed_d = diff;
		if (op_s1 == OP_CLEAR) begin
			stamp_d   = '0;
			pending_d = 1'b0;
			dead_d    = 1'b0;
			miss_d    = '0;
			elapsed_d = now_s1;
		end else if (cfg_i.enable) begin
			unique case (op_s1)
				OP_POLL: begin
					if (!dead_q && pending_q && overdue) begin
						pending_d = 1'b0;
						miss_d    = miss_inc;
						if (miss_inc >= cfg_i.miss_limit) begin
							dead_d  = 1'b1;
							fired_d = 1'b1;
						end
					end
				end
				OP_SENT: begin
					stamp_d   = now_s1;
					pending_d = 1'b1;
					elapsed_d = '0;
				end
				OP_PONG: begin
					pending_d = 1'b0;
					dead_d    = 1'b0;
					miss_d    = '0;
				end
				default: stamp_d = stamp_q;
			endcase
		end
	end

	// Hold the state; a register write clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q   <= '0;
			pending_q <= 1'b0;
			dead_q    <= 1'b0;
			miss_q    <= '0;
		end else if (cfg_i.clear) begin
			stamp_q   <= '0;
			pending_q <= 1'b0;
			dead_q    <= 1'b0;
			miss_q    <= '0;
		end else if (upd) begin
			stamp_q   <= stamp_d;
			pending_q <= pending_d;
			dead_q    <= dead_d;
			miss_q    <= miss_d;
		end
	end

	// Advance the status record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			st_s2.fired   <= fired_d;
			st_s2.dead    <= dead_d;
			st_s2.misses  <= miss_d;
			st_s2.pending <= pending_d;
			st_s2.active  <= cfg_i.enable && !dead_d && !pending_d;
			st_s2.elapsed <= elapsed_d;
		end
	end

	assign st_valid = valid_s2;
	assign st_o     = st_s2;

endmodule

/* rtl/hkm_wait_calc.sv */
`timescale 1ns / 1ps
// Due check and ms-until-next-heartbeat computation of the heartbeat
// keepalive monitor, ending in the result register. Uses hkm_pkg, hkm_intf.
module hkm_wait_calc (
	input  logic             clk,
	input  logic             arst_n,
	input  hkm_pkg::cfg_t    cfg_i,
	input  logic             st_valid,
	output logic             st_ready,
	input  hkm_pkg::status_t st_i,
	hkm_result_if.source     result
);
	import hkm_pkg::*;

	// Compare stage
	logic              valid_s3;
	logic              fired_s3;
	logic              dead_s3;
	logic [MISS_W-1:0] misses_s3;
	logic              pending_s3;
	logic              active_s3;
	logic              due_s3;
	logic [REM_W-1:0]  rem_s3;
	// Partial quotient stage
	logic              valid_s4;
	logic              fired_s4;
	logic              dead_s4;
	logic [MISS_W-1:0] misses_s4;
	logic              pending_s4;
	logic              active_s4;
	logic              due_s4;
	logic [MS_W-1:0]   hi_s4;
	logic [Y_W-1:0]    y_s4;
	// Result register
	logic              valid_q;
	logic              fired_q;
	logic              due_q;
	logic [MS_W-1:0]   wait_q;
	logic              dead_q;
	logic [MISS_W-1:0] misses_q;
	logic              pending_q;

	logic              adv_o;
	logic              adv4;
	logic              adv3;
	logic              due_c;
	logic [US_W-1:0]   rem_c;
	logic [HI_W-1:0]   a_c;
	logic [SPLIT-1:0]  b_c;
	logic [Y_W+24:0]   prod_c;
	logic [MS_W-1:0]   wait_c;

	assign adv_o    = !valid_q || result.ready;
	assign adv4     = !valid_s4 || adv_o;
	assign adv3     = !valid_s3 || adv4;
	assign st_ready = adv3;

	// Check whether a heartbeat is due and take the time remaining
	assign due_c = st_i.elapsed >= TIME_W'(cfg_i.ping_us);
	assign rem_c = cfg_i.ping_us - st_i.elapsed[US_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (adv3) valid_s3 <= st_valid;
			if (adv4) valid_s4 <= valid_s3;
			if (adv_o) valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && st_valid) begin
			fired_s3   <= st_i.fired;
			dead_s3    <= st_i.dead;
			misses_s3  <= st_i.misses;
			pending_s3 <= st_i.pending;
			active_s3  <= st_i.active;
			due_s3     <= due_c;
			rem_s3     <= rem_c[US_W-1:3];
		end
	end

	// Split the divide by 125 into a high product and a small remainder part
	assign a_c = rem_s3[REM_W-1:SPLIT];
	assign b_c = rem_s3[SPLIT-1:0];

	always_ff @(posedge clk) begin
		if (adv4 && valid_s3) begin
			fired_s4   <= fired_s3;
			dead_s4    <= dead_s3;
			misses_s4  <= misses_s3;
			pending_s4 <= pending_s3;
			active_s4  <= active_s3;
			due_s4     <= due_s3;
			hi_s4      <= MS_W'({15'd0, a_c} * {18'd0, DIV_HI});
			y_s4       <= Y_W'({6'd0, a_c} * {19'd0, DIV_MID}) + Y_W'(b_c);
		end
	end

	// Finish the quotient with the reciprocal and pick the reported wait
	assign prod_c = {25'd0, y_s4} * {24'd0, DIV_RCP};

	always_comb begin
		if (!active_s4) begin
			wait_c = cfg_i.ping_ms;
		end else if (due_s4) begin
			wait_c = '0;
		end else begin
			wait_c = hi_s4 + MS_W'(prod_c[Y_W+24:RCP_SH]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_o && valid_s4) begin
			fired_q   <= fired_s4;
			due_q     <= active_s4 && due_s4;
			wait_q    <= wait_c;
			dead_q    <= dead_s4;
			misses_q  <= misses_s4;
			pending_q <= pending_s4;
		end
	end

	assign result.valid         = valid_q;
	assign result.timeout_fired = fired_q;
	assign result.send_due      = due_q;
	assign result.wait_ms       = wait_q;
	assign result.peer_dead     = dead_q;
	assign result.misses        = misses_q;
	assign result.awaiting_pong = pending_q;

endmodule

/* rtl/heartbeat_keepalive_monitor.sv */
`timescale 1ns / 1ps
// Heartbeat keepalive monitor, top level. Instantiates hkm_cfg_regs,
// hkm_state_core and hkm_wait_calc; uses hkm_pkg and the hkm_intf channels.
//
// Each input item (poll, heartbeat sent, pong received, clear) with its
// microsecond timestamp yields exactly one result item. One item is accepted
// per clock while results are taken; the keepalive state (send stamp, pong
// pending, peer dead, miss count) is updated as the item leaves the input
// register, so consecutive items see each other's effects without stalls.
// A result passes the input register and state update, the due compare, and
// the divide of the remaining microseconds by 1000 before it is presented.
// A stalled result holds the pipeline only as far as it is full.
// Configuration writes are taken in any cycle, apply at once and clear the
// keepalive state; issue them only while no item is in flight.
module heartbeat_keepalive_monitor (
	input  logic         clk,
	input  logic         arst_n,
	hkm_item_if.sink     item,
	hkm_result_if.source result,
	hkm_cfg_if.sink      cfg
);
	import hkm_pkg::*;

	cfg_t    cfg_c;
	logic    st_valid;
	logic    st_ready;
	status_t st_c;

	hkm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_o  (cfg_c)
	);

	hkm_state_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_i    (cfg_c),
		.item     (item),
		.st_valid (st_valid),
		.st_ready (st_ready),
		.st_o     (st_c)
	);

	hkm_wait_calc u_wait (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_i    (cfg_c),
		.st_valid (st_valid),
		.st_ready (st_ready),
		.st_i     (st_c),
		.result   (result)
	);

endmodule
